FILE: hdl/fab_pkg.sv
// Shared constants for the first-fit block allocator.
package fab_pkg;

  localparam int SIZE_IN_W = 16;  // request size field
  localparam int ADDR_W    = 14;  // payload address field
  localparam int NEED_W    = 17;  // rounded request, up to 65535 + 63
  localparam int CMP_W     = 18;  // need + header + 1
  localparam int RECIP_SH  = NEED_W + 6;  // reciprocal shift, exact for alignment up to 64
  localparam int RECIP_W   = RECIP_SH + 1;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

FILE: hdl/fab_hdr_mem.sv
// Block header memory: one write port, one registered read port, entry zero preset at reset.
module fab_hdr_mem #(
  parameter int DEPTH = 656,
  parameter int AW = 10,
  parameter int DW = 15,
  parameter logic [DW-1:0] INIT_ENTRY = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] ra_i,
  input  logic          we_i,
  input  logic [AW-1:0] wa_i,
  input  logic [DW-1:0] wd_i,
  output logic [DW-1:0] rd_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_raw_q;
  logic          rd_init_q;
  logic          init_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_raw_q <= mem[ra_i];
    end
  end

  // entry zero reads as the whole-arena free block until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b1;
      rd_init_q <= 1'b0;
    end else begin
      if (we_i && wa_i == '0) begin
        init_q <= 1'b0;
      end
      if (re_i) begin
        rd_init_q <= init_q && ra_i == '0;
      end
    end
  end

  assign rd_o = rd_init_q ? INIT_ENTRY : rd_raw_q;

endmodule

FILE: hdl/first_fit_block_allocator.sv
// First-fit block allocator: top level with walk, split and merge sequencer.
//
// Input channel: in_valid_i / in_stall_o carry kind_i, alloc_size_i and
// block_address_i. A transfer takes place when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i carry ok_o and payload_address_o,
// one result per input item, in order.
// One item is worked on at a time; in_stall_o is high from the transfer
// until the result is loaded into the output register, so a new item may
// enter while that result still waits to be taken.
// Allocate: a rounding step and a scaling step, then a read and a check per
// block header visited; a split adds a read and a write per block moved behind
// the hit plus writes of both headers. Release: a read and a check per block
// in the arena (one compaction pass over the header memory). The header
// memory has a registered read port. Zero-size allocate and null release
// go straight to the finish state.
// Reset leaves one free block covering the arena; no clearing pass is needed.
// While the receiver stalls a finished result, the next item's work completes
// and waits until the output register is free.
module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = 16384,
  parameter int HEADER_BYTES = 24,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [fab_pkg::SIZE_IN_W-1:0] alloc_size_i,
  input  logic [fab_pkg::ADDR_W-1:0]   block_address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [fab_pkg::ADDR_W-1:0]   payload_address_o
);
  import fab_pkg::*;

  localparam int MAX_BLOCKS = ARENA_BYTES / (HEADER_BYTES + 1) + 1;
  localparam int AW     = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W = $clog2(ARENA_BYTES);
  localparam int OFF_W  = SIZE_W + 1;
  localparam int DW     = SIZE_W + 1;
  localparam int PROD_W = NEED_W + RECIP_W;
  localparam logic [SIZE_W-1:0] SIZE_INIT = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [DW-1:0] INIT_ENTRY = {1'b1, SIZE_INIT};
  localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SZ = SIZE_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0] HDR_CMP = CMP_W'(HEADER_BYTES + 1);
  localparam logic [NEED_W-1:0] ALIGN_M1 = NEED_W'(ALIGN_BYTES - 1);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SH + ALIGN_BYTES - 1) / ALIGN_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR,
    S_INS_T, S_INS_H, S_R_RD, S_R_CHK, S_R_LAST, S_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q, idx_q, wr_q;
  logic [OFF_W-1:0]    off_q;
  logic [NEED_W-1:0]   dvd_q, need_q;
  logic [ADDR_W-1:0]   rel_q, res_addr_q, out_addr_q;
  logic                res_ok_q, out_ok_q, out_valid_q;
  logic [SIZE_W-1:0]   rest_q, cur_size_q;
  logic                cur_free_q;
  logic [CNT_W-1:0]    hit_q;

  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_ra, mem_wa;
  logic [DW-1:0]       mem_wd, mem_rd;
  logic                e_free;
  logic [SIZE_W-1:0]   e_size;
  logic [PROD_W-1:0]   recip_prod;
  logic                out_busy;
  logic                load_out;
  logic [CMP_W-1:0]    split_lim;

  assign e_free     = mem_rd[DW-1];
  assign e_size     = mem_rd[SIZE_W-1:0];
  assign recip_prod = PROD_W'(dvd_q) * PROD_W'(RECIP);
  assign out_busy   = out_valid_q && out_stall_i;
  assign load_out   = state_q == S_FIN && !out_busy;
  assign split_lim  = CMP_W'(need_q) + HDR_CMP;

  fab_hdr_mem #(
    .DEPTH     (MAX_BLOCKS),
    .AW        (AW),
    .DW        (DW),
    .INIT_ENTRY(INIT_ENTRY)
  ) u_mem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .rd_o  (mem_rd)
  );

  always_comb begin
    mem_re = 1'b0;
    mem_ra = idx_q[AW-1:0];
    mem_we = 1'b0;
    mem_wa = idx_q[AW-1:0];
    mem_wd = mem_rd;
    unique case (state_q)
      S_A_RD, S_SH_RD, S_R_RD: mem_re = 1'b1;
      S_A_CHK: begin
        // hit without split: mark used in place
        if (e_free && CMP_W'(e_size) >= CMP_W'(need_q) &&
            !(CMP_W'(e_size) >= split_lim && cnt_q < CNT_MAX)) begin
          mem_we = 1'b1;
          mem_wd = {1'b0, e_size};
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx_q + 1'b1);
      end
      S_INS_T: begin
        mem_we = 1'b1;
        mem_wa = AW'(hit_q + 1'b1);
        mem_wd = {1'b1, rest_q};
      end
      S_INS_H: begin
        mem_we = 1'b1;
        mem_wa = hit_q[AW-1:0];
        mem_wd = {1'b0, SIZE_W'(need_q)};
      end
      S_R_CHK: begin
        // flush the accumulated block when no merge is possible
        if (idx_q != '0 && !(cur_free_q &&
            (e_free || (off_q + HDR_OFF) == OFF_W'(rel_q)))) begin
          mem_we = 1'b1;
          mem_wa = wr_q[AW-1:0];
          mem_wd = {cur_free_q, cur_size_q};
        end
      end
      S_R_LAST: begin
        mem_we = 1'b1;
        mem_wa = wr_q[AW-1:0];
        mem_wd = {cur_free_q, cur_size_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_ok_q    <= res_ok_q;
        out_addr_q  <= res_addr_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q <= '0;
            off_q <= '0;
            wr_q  <= '0;
            rel_q <= block_address_i;
            res_addr_q <= '0;
            if (kind_i == KIND_ALLOC) begin
              res_ok_q <= 1'b0;
              dvd_q    <= NEED_W'(alloc_size_i) + ALIGN_M1;
              state_q  <= (alloc_size_i == '0) ? S_FIN : S_DIV;
            end else begin
              res_ok_q <= 1'b1;
              state_q  <= (block_address_i == '0) ? S_FIN : S_R_RD;
            end
          end
        end
        S_DIV: begin
          // quotient by reciprocal multiply, exact over the whole request range
          dvd_q   <= recip_prod[RECIP_SH +: NEED_W];
          state_q <= S_MUL;
        end
        S_MUL: begin
          need_q  <= NEED_W'(dvd_q * NEED_W'(ALIGN_BYTES));
          state_q <= S_A_RD;
        end
        S_A_RD: state_q <= S_A_CHK;
        S_A_CHK: begin
          if (e_free && CMP_W'(e_size) >= CMP_W'(need_q)) begin
            res_ok_q   <= 1'b1;
            res_addr_q <= ADDR_W'(off_q + HDR_OFF);
            hit_q      <= idx_q;
            if (CMP_W'(e_size) >= split_lim && cnt_q < CNT_MAX) begin
              rest_q <= e_size - SIZE_W'(need_q) - HDR_SZ;
              idx_q  <= cnt_q - 1'b1;
              state_q <= (cnt_q - 1'b1 == idx_q) ? S_INS_T : S_SH_RD;
            end else begin
              state_q <= S_FIN;
            end
          end else begin
            off_q <= off_q + HDR_OFF + OFF_W'(e_size);
            idx_q <= idx_q + 1'b1;
            state_q <= (idx_q + 1'b1 == cnt_q) ? S_FIN : S_A_RD;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          idx_q   <= idx_q - 1'b1;
          state_q <= (idx_q - 1'b1 == hit_q) ? S_INS_T : S_SH_RD;
        end
        S_INS_T: state_q <= S_INS_H;
        S_INS_H: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_FIN;
        end
        S_R_RD: state_q <= S_R_CHK;
        S_R_CHK: begin
          off_q <= off_q + HDR_OFF + OFF_W'(e_size);
          if (idx_q == '0) begin
            cur_free_q <= e_free || (off_q + HDR_OFF) == OFF_W'(rel_q);
            cur_size_q <= e_size;
          end else if (cur_free_q && (e_free || (off_q + HDR_OFF) == OFF_W'(rel_q))) begin
            cur_size_q <= cur_size_q + HDR_SZ + e_size;
          end else begin
            wr_q       <= wr_q + 1'b1;
            cur_free_q <= e_free || (off_q + HDR_OFF) == OFF_W'(rel_q);
            cur_size_q <= e_size;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= (idx_q + 1'b1 == cnt_q) ? S_R_LAST : S_R_RD;
        end
        S_R_LAST: begin
          cnt_q   <= wr_q + 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = state_q != S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign payload_address_o = out_addr_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CNT_MAX)
    else $error("block count out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ok_q |-> out_addr_q == '0)
    else $error("failed allocate carries an address");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transfer did not start work");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && !out_busy |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

endmodule
